/* rtl/sec2date_pkg.sv */
// ----------------------------------------------------------------------------
// sec2date_pkg
// Constants and month tables for the seconds to calendar date converter.
// ----------------------------------------------------------------------------
`default_nettype none

package sec2date_pkg;

    // day of year, 0..365
    typedef logic [8:0] t_doy;

    // seconds per day = 2^7 * 675
    localparam int unsigned SEC_SHIFT       = 7;
    localparam logic [9:0]  DAY_DIV         = 10'd675;
    localparam logic [25:0] DAY_RECIP       = 26'd50903316;   // floor(2^35 / 675)
    localparam int unsigned DAY_RECIP_SHIFT = 35;

    // seconds per hour = 2^4 * 225
    localparam logic [7:0]  HOUR_DIV        = 8'd225;
    localparam logic [13:0] HOUR_RECIP      = 14'd9320;       // floor(2^21 / 225)
    localparam int unsigned HOUR_SHIFT      = 21;

    // days per four-year block
    localparam logic [10:0] BLOCK_DAYS      = 11'd1461;
    localparam logic [16:0] BLOCK_RECIP     = 17'd91867;      // floor(2^27 / 1461)
    localparam int unsigned BLOCK_SHIFT     = 27;

    // seconds per minute = 2^2 * 15
    localparam logic [3:0]  MIN_DIV         = 4'd15;
    localparam logic [10:0] MIN_RECIP       = 11'd1092;       // floor(2^14 / 15)
    localparam int unsigned MIN_SHIFT       = 14;

    // year lengths
    localparam logic [10:0] LEAP_DAYS       = 11'd366;
    localparam logic [10:0] PLAIN_DAYS      = 11'd365;

    localparam int unsigned LAST_MONTH      = 11;

    // first day of each month
    localparam t_doy MONTH_START_PLAIN [12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };
    localparam t_doy MONTH_START_LEAP [12] = '{
        9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
        9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335
    };

endpackage

`default_nettype wire

/* rtl/seconds_to_calendar_date.sv */
// ----------------------------------------------------------------------------
// seconds_to_calendar_date
// Converts seconds since 1980-01-01 00:00:00 into year offset, month, day,
// hour, minute and second through an eight stage pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid / o_ready carries one 32-bit seconds count per
//   transaction. Output channel o_valid / i_ready carries the six date and
//   time fields of the converted transaction, in input order.
//   Throughput is one transaction per cycle while the output is not
//   stalled: every constant division is a reciprocal multiply, a
//   product and a single compare-and-subtract correction, spread over
//   the register stages.
//   Each stage holds a valid bit and moves forward whenever the stage after
//   it is empty or moving, so bubbles close up while the receiver stalls and
//   o_ready drops only when all eight stages are full and i_ready is low.
//   Reset clears all valid bits; the pipeline is empty and o_ready is high in
//   the first cycle after reset. Years follow a plain four-year leap cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module seconds_to_calendar_date (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [31:0] i_seconds_since_1980,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_year_offset,
    output logic [3:0]       o_month_index,
    output logic [4:0]       o_day_index,
    output logic [4:0]       o_hour_of_day,
    output logic [5:0]       o_minute_of_hour,
    output logic [5:0]       o_second_of_minute
);

    localparam int unsigned PIPE_DEPTH = 8;

    // per-stage valid bits and advance enables
    logic [PIPE_DEPTH-1:0] r_vld;
    logic [PIPE_DEPTH-1:0] adv;

    // stage 1: day quotient estimate
    logic [31:0] r_s1_secs;
    logic [15:0] r_s1_qe;
    // stage 2: product of estimate and divisor
    logic [31:0] r_s2_secs;
    logic [15:0] r_s2_qe;
    logic [24:0] r_s2_pq;
    // stage 3: days and time of day
    logic [15:0] r_s3_days;
    logic [16:0] r_s3_tod;
    // stage 4: hour and block estimates
    logic [16:0] r_s4_tod;
    logic [15:0] r_s4_days;
    logic [4:0]  r_s4_he;
    logic [5:0]  r_s4_be;
    // stage 5: products of estimates
    logic [16:0] r_s5_tod;
    logic [15:0] r_s5_days;
    logic [4:0]  r_s5_he;
    logic [5:0]  r_s5_be;
    logic [12:0] r_s5_hp;
    logic [15:0] r_s5_bp;
    // stage 6: hour, rest of hour, block and day in block
    logic [4:0]  r_s6_hour;
    logic [11:0] r_s6_rest;
    logic [5:0]  r_s6_blocks;
    logic [10:0] r_s6_in_block;
    // stage 7: year in block, day of year, minute estimate
    logic [4:0]  r_s7_hour;
    logic [11:0] r_s7_rest;
    logic [5:0]  r_s7_blocks;
    logic [1:0]  r_s7_yib;
    logic [8:0]  r_s7_doy;
    logic        r_s7_leap;
    logic [5:0]  r_s7_me;
    // stage 8: output register
    logic [7:0]  r_s8_year;
    logic [3:0]  r_s8_month;
    logic [4:0]  r_s8_day;
    logic [4:0]  r_s8_hour;
    logic [5:0]  r_s8_minute;
    logic [5:0]  r_s8_second;

    // next values
    logic [50:0] n_s1_prod;
    logic [25:0] n_s2_prod;
    logic [15:0] n_s3_days;
    logic [16:0] n_s3_tod;
    logic [26:0] n_s4_hprod;
    logic [32:0] n_s4_bprod;
    logic [12:0] n_s5_hp;
    logic [16:0] n_s5_bprod;
    logic [4:0]  n_s6_hour;
    logic [11:0] n_s6_rest;
    logic [5:0]  n_s6_blocks;
    logic [10:0] n_s6_in_block;
    logic [1:0]  n_s7_yib;
    logic [8:0]  n_s7_doy;
    logic [20:0] n_s7_mprod;
    logic [7:0]  n_s8_year;
    logic [3:0]  n_s8_month;
    logic [4:0]  n_s8_day;
    logic [5:0]  n_s8_minute;
    logic [5:0]  n_s8_second;

    // advance chain: a stage moves when it is empty or the next one moves
    always_comb begin
        adv[PIPE_DEPTH-1] = ~r_vld[PIPE_DEPTH-1] | i_ready;
        for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
            adv[k] = ~r_vld[k] | adv[k+1];
        end
    end

    assign o_ready = adv[0];
    assign o_valid = r_vld[PIPE_DEPTH-1];

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < PIPE_DEPTH; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 1: reciprocal multiply for seconds / 86400
    assign n_s1_prod = 51'(i_seconds_since_1980[31:sec2date_pkg::SEC_SHIFT])
                     * 51'(sec2date_pkg::DAY_RECIP);

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_s1_secs <= i_seconds_since_1980;
            r_s1_qe   <= n_s1_prod[50:sec2date_pkg::DAY_RECIP_SHIFT];
        end
    end

    // stage 2: estimate times divisor
    assign n_s2_prod = 26'(r_s1_qe) * 26'(sec2date_pkg::DAY_DIV);

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r_s2_secs <= r_s1_secs;
            r_s2_qe   <= r_s1_qe;
            r_s2_pq   <= n_s2_prod[24:0];
        end
    end

    // stage 3: remainder and one-step correction
    always_comb begin
        logic [24:0] diff;
        logic [10:0] rem;
        diff      = r_s2_secs[31:sec2date_pkg::SEC_SHIFT] - r_s2_pq;
        rem       = diff[10:0];
        n_s3_days = r_s2_qe;
        if (rem >= 11'(sec2date_pkg::DAY_DIV)) begin
            n_s3_days = r_s2_qe + 16'd1;
            rem       = rem - 11'(sec2date_pkg::DAY_DIV);
        end
        n_s3_tod = {rem[9:0], r_s2_secs[sec2date_pkg::SEC_SHIFT-1:0]};
    end

    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            r_s3_days <= n_s3_days;
            r_s3_tod  <= n_s3_tod;
        end
    end

    // stage 4: estimates for tod / 3600 and days / 1461
    assign n_s4_hprod = 27'(r_s3_tod[16:4]) * 27'(sec2date_pkg::HOUR_RECIP);
    assign n_s4_bprod = 33'(r_s3_days) * 33'(sec2date_pkg::BLOCK_RECIP);

    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            r_s4_tod  <= r_s3_tod;
            r_s4_days <= r_s3_days;
            r_s4_he   <= n_s4_hprod[sec2date_pkg::HOUR_SHIFT+4:sec2date_pkg::HOUR_SHIFT];
            r_s4_be   <= n_s4_bprod[32:sec2date_pkg::BLOCK_SHIFT];
        end
    end

    // stage 5: estimates times divisors
    assign n_s5_hp    = 13'(r_s4_he) * 13'(sec2date_pkg::HOUR_DIV);
    assign n_s5_bprod = 17'(r_s4_be) * 17'(sec2date_pkg::BLOCK_DAYS);

    always_ff @(posedge i_clk) begin
        if (adv[4]) begin
            r_s5_tod  <= r_s4_tod;
            r_s5_days <= r_s4_days;
            r_s5_he   <= r_s4_he;
            r_s5_be   <= r_s4_be;
            r_s5_hp   <= n_s5_hp;
            r_s5_bp   <= n_s5_bprod[15:0];
        end
    end

    // stage 6: hour and block corrections
    always_comb begin
        logic [12:0] hdiff;
        logic [8:0]  hrem;
        logic [15:0] bdiff;
        logic [11:0] brem;
        hdiff     = r_s5_tod[16:4] - r_s5_hp;
        hrem      = hdiff[8:0];
        n_s6_hour = r_s5_he;
        if (hrem >= 9'(sec2date_pkg::HOUR_DIV)) begin
            n_s6_hour = r_s5_he + 5'd1;
            hrem      = hrem - 9'(sec2date_pkg::HOUR_DIV);
        end
        n_s6_rest = {hrem[7:0], r_s5_tod[3:0]};

        bdiff       = r_s5_days - r_s5_bp;
        brem        = bdiff[11:0];
        n_s6_blocks = r_s5_be;
        if (brem >= 12'(sec2date_pkg::BLOCK_DAYS)) begin
            n_s6_blocks = r_s5_be + 6'd1;
            brem        = brem - 12'(sec2date_pkg::BLOCK_DAYS);
        end
        n_s6_in_block = brem[10:0];
    end

    always_ff @(posedge i_clk) begin
        if (adv[5]) begin
            r_s6_hour     <= n_s6_hour;
            r_s6_rest     <= n_s6_rest;
            r_s6_blocks   <= n_s6_blocks;
            r_s6_in_block <= n_s6_in_block;
        end
    end

    // stage 7: year within block and minute estimate
    always_comb begin
        logic [10:0] after;
        after = r_s6_in_block - sec2date_pkg::LEAP_DAYS;
        if (r_s6_in_block < sec2date_pkg::LEAP_DAYS) begin
            n_s7_yib = 2'd0;
            n_s7_doy = r_s6_in_block[8:0];
        end else if (after >= 11'(2 * sec2date_pkg::PLAIN_DAYS)) begin
            n_s7_yib = 2'd3;
            n_s7_doy = 9'(after - 11'(2 * sec2date_pkg::PLAIN_DAYS));
        end else if (after >= sec2date_pkg::PLAIN_DAYS) begin
            n_s7_yib = 2'd2;
            n_s7_doy = 9'(after - sec2date_pkg::PLAIN_DAYS);
        end else begin
            n_s7_yib = 2'd1;
            n_s7_doy = after[8:0];
        end
    end

    assign n_s7_mprod = 21'(r_s6_rest[11:2]) * 21'(sec2date_pkg::MIN_RECIP);

    always_ff @(posedge i_clk) begin
        if (adv[6]) begin
            r_s7_hour   <= r_s6_hour;
            r_s7_rest   <= r_s6_rest;
            r_s7_blocks <= r_s6_blocks;
            r_s7_yib    <= n_s7_yib;
            r_s7_doy    <= n_s7_doy;
            r_s7_leap   <= (r_s6_in_block < sec2date_pkg::LEAP_DAYS);
            r_s7_me     <= n_s7_mprod[sec2date_pkg::MIN_SHIFT+5:sec2date_pkg::MIN_SHIFT];
        end
    end

    // stage 8: minute correction, month search, day and year
    always_comb begin
        logic [9:0]              mp;
        logic [9:0]              mdiff;
        logic [4:0]              mrem;
        sec2date_pkg::t_doy      start;
        mp          = 10'(r_s7_me) * 10'(sec2date_pkg::MIN_DIV);
        mdiff       = r_s7_rest[11:2] - mp;
        mrem        = mdiff[4:0];
        n_s8_minute = r_s7_me;
        if (mrem >= 5'(sec2date_pkg::MIN_DIV)) begin
            n_s8_minute = r_s7_me + 6'd1;
            mrem        = mrem - 5'(sec2date_pkg::MIN_DIV);
        end
        n_s8_second = {mrem[3:0], r_s7_rest[1:0]};

        // last month whose first day is not after the day of year
        n_s8_month = '0;
        for (int i = 1; i <= sec2date_pkg::LAST_MONTH; i++) begin
            if ((r_s7_leap ? sec2date_pkg::MONTH_START_LEAP[i]
                           : sec2date_pkg::MONTH_START_PLAIN[i]) <= r_s7_doy) begin
                n_s8_month = 4'(i);
            end
        end
        start     = r_s7_leap ? sec2date_pkg::MONTH_START_LEAP[n_s8_month]
                              : sec2date_pkg::MONTH_START_PLAIN[n_s8_month];
        n_s8_day  = 5'(r_s7_doy - start);
        n_s8_year = {r_s7_blocks, 2'b00} + 8'(r_s7_yib);
    end

    always_ff @(posedge i_clk) begin
        if (adv[7]) begin
            r_s8_year   <= n_s8_year;
            r_s8_month  <= n_s8_month;
            r_s8_day    <= n_s8_day;
            r_s8_hour   <= r_s7_hour;
            r_s8_minute <= n_s8_minute;
            r_s8_second <= n_s8_second;
        end
    end

    assign o_year_offset      = r_s8_year;
    assign o_month_index      = r_s8_month;
    assign o_day_index        = r_s8_day;
    assign o_hour_of_day      = r_s8_hour;
    assign o_minute_of_hour   = r_s8_minute;
    assign o_second_of_minute = r_s8_second;

endmodule

`default_nettype wire

/* rtl/sec2date_checker.sv */
// ----------------------------------------------------------------------------
// sec2date_checker
// Port-level checks for the seconds to calendar date converter.
// ----------------------------------------------------------------------------
`default_nettype none

module sec2date_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_ready,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [7:0]  o_year_offset,
    input wire logic [3:0]  o_month_index,
    input wire logic [4:0]  o_day_index,
    input wire logic [4:0]  o_hour_of_day,
    input wire logic [5:0]  o_minute_of_hour,
    input wire logic [5:0]  o_second_of_minute
);

    // pipeline is empty after reset
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    // with no result waiting, the pipeline can always take a transaction
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input not ready while output stage is empty");

    // every delivered field stays in its calendar range
    a_field_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_year_offset <= 8'd136) && (o_month_index <= 4'd11)
                 && (o_day_index <= 5'd30) && (o_hour_of_day <= 5'd23)
                 && (o_minute_of_hour <= 6'd59) && (o_second_of_minute <= 6'd59))
        else $error("output field out of range");

    // a stalled result holds its payload
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_year_offset)
            && $stable(o_month_index) && $stable(o_day_index)
            && $stable(o_hour_of_day) && $stable(o_minute_of_hour)
            && $stable(o_second_of_minute))
        else $error("stalled output transaction changed");

endmodule

bind seconds_to_calendar_date sec2date_checker u_sec2date_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_ready            (o_ready),
    .o_valid            (o_valid),
    .i_ready            (i_ready),
    .o_year_offset      (o_year_offset),
    .o_month_index      (o_month_index),
    .o_day_index        (o_day_index),
    .o_hour_of_day      (o_hour_of_day),
    .o_minute_of_hour   (o_minute_of_hour),
    .o_second_of_minute (o_second_of_minute)
);

`default_nettype wire
